/* src/cpr_pkg.sv */
// Shared types and constants for the cashless poll response parser.
`timescale 1ns / 1ps
package cpr_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   // response codes
   localparam logic [7:0] CODE_JUST_RESET     = 8'h00;
   localparam logic [7:0] CODE_READER_CONFIG  = 8'h01;
   localparam logic [7:0] CODE_DISPLAY_REQ    = 8'h02;
   localparam logic [7:0] CODE_BEGIN_SESSION  = 8'h03;
   localparam logic [7:0] CODE_CANCEL_REQ     = 8'h04;
   localparam logic [7:0] CODE_VEND_APPROVED  = 8'h05;
   localparam logic [7:0] CODE_VEND_DENIED    = 8'h06;
   localparam logic [7:0] CODE_END_SESSION    = 8'h07;
   localparam logic [7:0] CODE_CANCELLED      = 8'h08;
   localparam logic [7:0] CODE_PERIPHERAL_ID  = 8'h09;
   localparam logic [7:0] CODE_MALFUNCTION    = 8'h0A;
   localparam logic [7:0] CODE_CMD_OUT_SEQ    = 8'h0B;

   // payload lengths skipped after a code
   localparam logic [2:0] SKIP_READER_CONFIG = 3'd7;
   localparam logic [2:0] SKIP_APPROVED      = 3'd2;
   localparam logic [2:0] SKIP_MALFUNCTION   = 3'd1;

   // event flag bit positions
   localparam int unsigned FLAG_JUST_RESET  = 0;
   localparam int unsigned FLAG_BEGIN       = 1;
   localparam int unsigned FLAG_CANCEL      = 2;
   localparam int unsigned FLAG_APPROVED    = 3;
   localparam int unsigned FLAG_DENIED      = 4;
   localparam int unsigned FLAG_END_SESSION = 5;
   localparam int unsigned FLAG_MALFUNCTION = 6;
   localparam int unsigned FLAG_CMD_ERROR   = 7;

   // reader levels
   localparam logic [7:0] LEVEL_1 = 8'd1;
   localparam logic [7:0] LEVEL_2 = 8'd2;
   localparam logic [7:0] LEVEL_3 = 8'd3;

   // begin session field positions
   localparam logic [3:0] SIDX_FUNDS_HI    = 4'd0;
   localparam logic [3:0] SIDX_FUNDS_LO    = 4'd1;
   localparam logic [3:0] SIDX_ID_3        = 4'd2;
   localparam logic [3:0] SIDX_ID_2        = 4'd3;
   localparam logic [3:0] SIDX_ID_1        = 4'd4;
   localparam logic [3:0] SIDX_ID_0        = 4'd5;
   localparam logic [3:0] SIDX_KIND        = 4'd6;
   localparam logic [3:0] SIDX_L1_FUNDS_HI = 4'd8;
   localparam logic [3:0] SIDX_L1_FUNDS_LO = 4'd9;

   // configuration register indexes
   localparam logic CSR_READER_LEVEL = 1'b0;
   localparam logic CSR_AMOUNT_SCALE = 1'b1;

   typedef enum logic [1:0] {
      PH_CODE    = 2'd0,
      PH_SKIP    = 2'd1,
      PH_SESSION = 2'd2,
      PH_STOP    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  event_flags;
      logic [30:0] received_amount;
      logic [31:0] payment_id;
      logic [7:0]  payment_kind;
   } rsp_type;

   // parsed response handed from the parser to the back end
   typedef struct packed {
      logic [7:0]  flags;
      logic [15:0] funds;
      logic [31:0] media_id;
      logic [7:0]  media_kind;
   } parse_rec_type;

endpackage

/* src/cashless_poll_response_parser.sv */
// A final byte's record goes into the record queue, then into the output register.
// Throughput: one byte per cycle while req_full is low; the parser step and
// the scale multiply in the back end are combinational logic.
// A two-entry record queue and an output register let producer and consumer stall apart.
// Reset (synchronous, active high) clears the parser, queue and output valid;
// reader_level returns to 1 and amount_scale to 100.
`timescale 1ns / 1ps
module cashless_poll_response_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cpr_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cpr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [14:0]      csr_wdata
);

   logic [7:0]             reader_level_ff, reader_level_in;
   logic [14:0]            amount_scale_ff, amount_scale_in;
   logic                   q_push, q_full, q_pop, q_empty;
   cpr_pkg::parse_rec_type q_wdata, q_head;

   always_comb begin
      reader_level_in = reader_level_ff;
      amount_scale_in = amount_scale_ff;
      if (csr_we) begin
         case (csr_index)
            cpr_pkg::CSR_READER_LEVEL: reader_level_in = csr_wdata[7:0];
            cpr_pkg::CSR_AMOUNT_SCALE: amount_scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reader_level_ff <= 8'd1;
         amount_scale_ff <= 15'd100;
      end else begin
         reader_level_ff <= reader_level_in;
         amount_scale_ff <= amount_scale_in;
      end
   end

   cpr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .reader_level (reader_level_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   cpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   cpr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .amount_scale (amount_scale_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

   // everything drains on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && q_empty && !req_full)
      else $error("queue or output not cleared by reset");

   // a waiting record is never lost while the output register is held
   a_hold_queue: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop && !q_empty) |=> !q_empty)
      else $error("queued record dropped while output stalled");

   // a queued record moves into an empty output register at once
   a_fill_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !q_empty) |=> !rsp_empty)
      else $error("output register not loaded from queue");

   // a final byte taken when nothing is queued or shown reaches the queue, then the output
   a_last_byte_out: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_data.last_byte && q_empty && rsp_empty)
      |=> (!q_empty && rsp_empty) ##1 !rsp_empty)
      else $error("final byte produced no transaction");

endmodule

/* src/cpr_front.sv */
// Byte parser: walks the poll response and emits one record per response.
`timescale 1ns / 1ps
module cpr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  cpr_pkg::req_type       req_data,
   input  logic [7:0]             reader_level,
   input  logic                   q_full,
   output logic                   q_push,
   output cpr_pkg::parse_rec_type q_data
);

   cpr_pkg::phase_type phase_ff, phase_in, phase_upd;
   logic [2:0]  skip_ff, skip_in, skip_upd;
   logic [3:0]  sidx_ff, sidx_in, sidx_upd;
   logic [7:0]  flags_ff, flags_in, flags_upd;
   logic [15:0] funds_ff, funds_in, funds_upd;
   logic [31:0] media_id_ff, media_id_in, media_id_upd;
   logic [7:0]  media_kind_ff, media_kind_in, media_kind_upd;
   logic        accept;
   logic [7:0]  b;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign b        = req_data.rx_byte;

   // next state
   always_comb begin
      phase_upd      = phase_ff;
      skip_upd       = skip_ff;
      sidx_upd       = sidx_ff;
      flags_upd      = flags_ff;
      funds_upd      = funds_ff;
      media_id_upd   = media_id_ff;
      media_kind_upd = media_kind_ff;
      if (accept) begin
         case (phase_ff)
            cpr_pkg::PH_CODE: begin
               case (b)
                  cpr_pkg::CODE_JUST_RESET: flags_upd[cpr_pkg::FLAG_JUST_RESET] = 1'b1;
                  cpr_pkg::CODE_READER_CONFIG: begin
                     skip_upd  = cpr_pkg::SKIP_READER_CONFIG;
                     phase_upd = cpr_pkg::PH_SKIP;
                  end
                  cpr_pkg::CODE_BEGIN_SESSION: begin
                     if (reader_level == cpr_pkg::LEVEL_1) begin
                        flags_upd[cpr_pkg::FLAG_BEGIN] = 1'b1;
                        sidx_upd  = cpr_pkg::SIDX_L1_FUNDS_HI;
                        phase_upd = cpr_pkg::PH_SESSION;
                     end else if (reader_level == cpr_pkg::LEVEL_2 ||
                                  reader_level == cpr_pkg::LEVEL_3) begin
                        flags_upd[cpr_pkg::FLAG_BEGIN] = 1'b1;
                        sidx_upd  = cpr_pkg::SIDX_FUNDS_HI;
                        phase_upd = cpr_pkg::PH_SESSION;
                     end else begin
                        phase_upd = cpr_pkg::PH_STOP;
                     end
                  end
                  cpr_pkg::CODE_CANCEL_REQ: flags_upd[cpr_pkg::FLAG_CANCEL] = 1'b1;
                  cpr_pkg::CODE_VEND_APPROVED: begin
                     flags_upd[cpr_pkg::FLAG_APPROVED] = 1'b1;
                     skip_upd  = cpr_pkg::SKIP_APPROVED;
                     phase_upd = cpr_pkg::PH_SKIP;
                  end
                  cpr_pkg::CODE_VEND_DENIED: flags_upd[cpr_pkg::FLAG_DENIED] = 1'b1;
                  cpr_pkg::CODE_END_SESSION: flags_upd[cpr_pkg::FLAG_END_SESSION] = 1'b1;
                  cpr_pkg::CODE_CANCELLED: ;
                  cpr_pkg::CODE_MALFUNCTION: begin
                     flags_upd[cpr_pkg::FLAG_MALFUNCTION] = 1'b1;
                     skip_upd  = cpr_pkg::SKIP_MALFUNCTION;
                     phase_upd = cpr_pkg::PH_SKIP;
                  end
                  cpr_pkg::CODE_CMD_OUT_SEQ: flags_upd[cpr_pkg::FLAG_CMD_ERROR] = 1'b1;
                  // display request, peripheral id and unknown codes end parsing
                  default: phase_upd = cpr_pkg::PH_STOP;
               endcase
            end
            cpr_pkg::PH_SKIP: begin
               skip_upd = skip_ff - 3'd1;
               if (skip_upd == 3'd0) begin
                  phase_upd = cpr_pkg::PH_CODE;
               end
            end
            cpr_pkg::PH_SESSION: begin
               case (sidx_ff)
                  cpr_pkg::SIDX_FUNDS_HI, cpr_pkg::SIDX_L1_FUNDS_HI: begin
                     funds_upd = {b, 8'h00};
                  end
                  cpr_pkg::SIDX_FUNDS_LO, cpr_pkg::SIDX_L1_FUNDS_LO: begin
                     funds_upd = {funds_ff[15:8], b};
                  end
                  cpr_pkg::SIDX_ID_3, cpr_pkg::SIDX_ID_2,
                  cpr_pkg::SIDX_ID_1, cpr_pkg::SIDX_ID_0: begin
                     media_id_upd = {media_id_ff[23:0], b};
                  end
                  default: media_kind_upd = b;
               endcase
               if (sidx_ff == cpr_pkg::SIDX_KIND || sidx_ff == cpr_pkg::SIDX_L1_FUNDS_LO) begin
                  phase_upd = cpr_pkg::PH_STOP;
               end else begin
                  sidx_upd = sidx_ff + 4'd1;
               end
            end
            default: ;
         endcase
      end

      phase_in      = phase_upd;
      skip_in       = skip_upd;
      sidx_in       = sidx_upd;
      flags_in      = flags_upd;
      funds_in      = funds_upd;
      media_id_in   = media_id_upd;
      media_kind_in = media_kind_upd;
      // final byte closes the response and clears for the next one
      if (accept && req_data.last_byte) begin
         phase_in      = cpr_pkg::PH_CODE;
         skip_in       = 3'd0;
         sidx_in       = 4'd0;
         flags_in      = 8'd0;
         funds_in      = 16'd0;
         media_id_in   = 32'd0;
         media_kind_in = 8'd0;
      end
   end

   // outputs
   always_comb begin
      q_push            = accept && req_data.last_byte;
      q_data.flags      = flags_upd;
      q_data.funds      = funds_upd;
      q_data.media_id   = media_id_upd;
      q_data.media_kind = media_kind_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cpr_pkg::PH_CODE;
         skip_ff       <= 3'd0;
         sidx_ff       <= 4'd0;
         flags_ff      <= 8'd0;
         funds_ff      <= 16'd0;
         media_id_ff   <= 32'd0;
         media_kind_ff <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         skip_ff       <= skip_in;
         sidx_ff       <= sidx_in;
         flags_ff      <= flags_in;
         funds_ff      <= funds_in;
         media_id_ff   <= media_id_in;
         media_kind_ff <= media_kind_in;
      end
   end

endmodule

/* src/cpr_queue.sv */
// Two-entry queue of parsed records between parser and back end.
`timescale 1ns / 1ps
module cpr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cpr_pkg::parse_rec_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output cpr_pkg::parse_rec_type head
);

   localparam int unsigned PTR_W = $clog2(cpr_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(cpr_pkg::QUEUE_DEPTH + 1);

   cpr_pkg::parse_rec_type entry_ff [cpr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(cpr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(cpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(cpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/cpr_back.sv */
// Back end: scales the funds and holds the result until it is popped.
`timescale 1ns / 1ps
module cpr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  cpr_pkg::parse_rec_type q_head,
   output logic                   q_pop,
   input  logic [14:0]            amount_scale,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output cpr_pkg::rsp_type       rsp_data
);

   logic             out_valid_ff, out_valid_in;
   cpr_pkg::rsp_type out_data_ff, out_data_in;
   logic             take;

   assign take      = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = take;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      out_data_in.event_flags     = q_head.flags;
      // 16 x 15 bit product fits exactly in 31 bits
      out_data_in.received_amount = {15'd0, q_head.funds} * {16'd0, amount_scale};
      out_data_in.payment_id      = q_head.media_id;
      out_data_in.payment_kind    = q_head.media_kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the cashless poll response parser.
`timescale 1ns / 1ps
module testbench;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 170;
   localparam int NUM_PHASES = 9;
   localparam int DIRECTED_ROWS = 26;
   localparam int SETTLE_CYCLES = 4;
   localparam int PICK_RANDOM = -1;
   localparam logic [14:0] SCALE_MAX = 15'd25500;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      logic [7:0]       rx;
      logic             last;
      logic             typed;
      cpr_pkg::rsp_type want;
   } directed_row_type;

   localparam cpr_pkg::rsp_type NOT_TYPED = '0;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push;
   logic             req_full;
   cpr_pkg::req_type req_data;
   logic             rsp_empty;
   logic             rsp_pop;
   cpr_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [14:0]      csr_wdata;

   // parser mirror: settings and per-response state
   logic [7:0]         model_level = cpr_pkg::LEVEL_1;
   logic [14:0]        model_scale = 15'd100;
   cpr_pkg::phase_type parse_state = cpr_pkg::PH_CODE;
   logic [2:0]         bytes_to_skip = '0;
   logic [3:0]         field_pos = '0;
   logic [7:0]         seen_flags = '0;
   logic [15:0]        session_funds = '0;
   logic [31:0]        media_id_acc = '0;
   logic [7:0]         media_kind_acc = '0;

   cpr_pkg::rsp_type expected_reports[$];
   int error_count = 0;
   int stall_cycles = 0;
   int sender_max_gap = 3;
   int sink_max_stall = 3;
   bit hold_off_request = 1'b0;

   // directed transactions at reset settings (level 1, scale 100)
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{cpr_pkg::CODE_JUST_RESET,    1'b1, 1'b1, '{8'h01, 31'd0, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_CMD_OUT_SEQ,   1'b1, 1'b1, '{8'h80, 31'd0, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_CANCEL_REQ,    1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_VEND_DENIED,   1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_END_SESSION,   1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_CANCELLED,     1'b1, 1'b1, '{8'h34, 31'd0, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_VEND_APPROVED, 1'b0, 1'b0, NOT_TYPED},
      '{8'hFF,                       1'b0, 1'b0, NOT_TYPED},
      '{8'hFF,                       1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_MALFUNCTION,   1'b0, 1'b0, NOT_TYPED},
      '{8'h80,                       1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_JUST_RESET,    1'b1, 1'b1, '{8'h49, 31'd0, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_BEGIN_SESSION, 1'b0, 1'b0, NOT_TYPED},
      '{8'hFF,                       1'b0, 1'b0, NOT_TYPED},
      '{8'hFF,                       1'b1, 1'b1, '{8'h02, 31'd6553500, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_BEGIN_SESSION, 1'b0, 1'b0, NOT_TYPED},
      '{8'h12,                       1'b1, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_DISPLAY_REQ,   1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_JUST_RESET,    1'b1, 1'b1, '{8'h00, 31'd0, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_READER_CONFIG, 1'b0, 1'b0, NOT_TYPED},
      '{8'h00,                       1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_CMD_OUT_SEQ,   1'b1, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_PERIPHERAL_ID, 1'b0, 1'b0, NOT_TYPED},
      '{cpr_pkg::CODE_JUST_RESET,    1'b1, 1'b0, NOT_TYPED},
      '{8'hFF,                       1'b1, 1'b1, '{8'h00, 31'd0, 32'd0, 8'd0}},
      '{cpr_pkg::CODE_VEND_APPROVED, 1'b1, 1'b1, '{8'h08, 31'd0, 32'd0, 8'd0}}
   };

   int phase_levels [NUM_PHASES] = '{2, 3, 1, 0, 255, 2, 3, PICK_RANDOM, 1};
   int phase_scales [NUM_PHASES] = '{25500, 0, 1, PICK_RANDOM, 25500, PICK_RANDOM,
                                     PICK_RANDOM, 100, PICK_RANDOM};

   cashless_poll_response_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Advances the mirror by one byte; returns 1 with the report on a final byte.
   function automatic bit parse_poll_byte(input cpr_pkg::req_type item,
                                          output cpr_pkg::rsp_type report);
      logic [7:0] b;
      logic [30:0] amount;
      b = item.rx_byte;
      report = '0;
      case (parse_state)
         cpr_pkg::PH_CODE: begin
            case (b)
               cpr_pkg::CODE_JUST_RESET: seen_flags[cpr_pkg::FLAG_JUST_RESET] = 1'b1;
               cpr_pkg::CODE_READER_CONFIG: begin
                  bytes_to_skip = cpr_pkg::SKIP_READER_CONFIG;
                  parse_state = cpr_pkg::PH_SKIP;
               end
               cpr_pkg::CODE_BEGIN_SESSION: begin
                  if (model_level == cpr_pkg::LEVEL_1) begin
                     seen_flags[cpr_pkg::FLAG_BEGIN] = 1'b1;
                     field_pos = cpr_pkg::SIDX_L1_FUNDS_HI;
                     parse_state = cpr_pkg::PH_SESSION;
                  end else if (model_level == cpr_pkg::LEVEL_2 ||
                               model_level == cpr_pkg::LEVEL_3) begin
                     seen_flags[cpr_pkg::FLAG_BEGIN] = 1'b1;
                     field_pos = cpr_pkg::SIDX_FUNDS_HI;
                     parse_state = cpr_pkg::PH_SESSION;
                  end else begin
                     parse_state = cpr_pkg::PH_STOP;
                  end
               end
               cpr_pkg::CODE_CANCEL_REQ: seen_flags[cpr_pkg::FLAG_CANCEL] = 1'b1;
               cpr_pkg::CODE_VEND_APPROVED: begin
                  seen_flags[cpr_pkg::FLAG_APPROVED] = 1'b1;
                  bytes_to_skip = cpr_pkg::SKIP_APPROVED;
                  parse_state = cpr_pkg::PH_SKIP;
               end
               cpr_pkg::CODE_VEND_DENIED: seen_flags[cpr_pkg::FLAG_DENIED] = 1'b1;
               cpr_pkg::CODE_END_SESSION: seen_flags[cpr_pkg::FLAG_END_SESSION] = 1'b1;
               cpr_pkg::CODE_CANCELLED: ;
               cpr_pkg::CODE_MALFUNCTION: begin
                  seen_flags[cpr_pkg::FLAG_MALFUNCTION] = 1'b1;
                  bytes_to_skip = cpr_pkg::SKIP_MALFUNCTION;
                  parse_state = cpr_pkg::PH_SKIP;
               end
               cpr_pkg::CODE_CMD_OUT_SEQ: seen_flags[cpr_pkg::FLAG_CMD_ERROR] = 1'b1;
               default: parse_state = cpr_pkg::PH_STOP;
            endcase
         end
         cpr_pkg::PH_SKIP: begin
            bytes_to_skip = bytes_to_skip - 3'd1;
            if (bytes_to_skip == 3'd0) parse_state = cpr_pkg::PH_CODE;
         end
         cpr_pkg::PH_SESSION: begin
            case (field_pos)
               cpr_pkg::SIDX_FUNDS_HI, cpr_pkg::SIDX_L1_FUNDS_HI:
                  session_funds = {b, 8'h00};
               cpr_pkg::SIDX_FUNDS_LO, cpr_pkg::SIDX_L1_FUNDS_LO:
                  session_funds[7:0] = b;
               cpr_pkg::SIDX_ID_3, cpr_pkg::SIDX_ID_2,
               cpr_pkg::SIDX_ID_1, cpr_pkg::SIDX_ID_0:
                  media_id_acc = {media_id_acc[23:0], b};
               default: media_kind_acc = b;
            endcase
            if (field_pos == cpr_pkg::SIDX_KIND || field_pos == cpr_pkg::SIDX_L1_FUNDS_LO)
               parse_state = cpr_pkg::PH_STOP;
            else
               field_pos = field_pos + 4'd1;
         end
         default: ;
      endcase
      if (!item.last_byte) return 1'b0;
      amount = session_funds * model_scale;
      report.event_flags = seen_flags;
      report.received_amount = amount;
      report.payment_id = media_id_acc;
      report.payment_kind = media_kind_acc;
      parse_state = cpr_pkg::PH_CODE;
      bytes_to_skip = '0;
      field_pos = '0;
      seen_flags = '0;
      session_funds = '0;
      media_id_acc = '0;
      media_kind_acc = '0;
      return 1'b1;
   endfunction

   task automatic send_byte(input cpr_pkg::req_type item, input logic typed,
                            input cpr_pkg::rsp_type typed_rsp);
      int gap;
      cpr_pkg::rsp_type predicted;
      gap = $urandom_range(0, sender_max_gap);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      if (parse_poll_byte(item, predicted))
         expected_reports.push_back(typed ? typed_rsp : predicted);
   endtask

   // Stop offering and let every pending transaction and any in-flight byte settle.
   task automatic drain_block();
      req_push <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(input logic [7:0] level, input logic [14:0] scale);
      csr_we <= 1'b1;
      csr_index <= cpr_pkg::CSR_READER_LEVEL;
      csr_wdata <= {7'd0, level};
      @(posedge clock);
      csr_index <= cpr_pkg::CSR_AMOUNT_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_we <= 1'b0;
      model_level = level;
      model_scale = scale;
   endtask

   // Mostly well-formed responses with random payloads; some noise and truncation.
   task automatic build_response(output byte_queue_type bytes);
      int records;
      int pick;
      int extra;
      int keep;
      logic [7:0] code;
      bytes = {};
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      records = $urandom_range(1, 4);
      repeat (records) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0: code = cpr_pkg::CODE_JUST_RESET;
            1: code = cpr_pkg::CODE_READER_CONFIG;
            2: code = cpr_pkg::CODE_DISPLAY_REQ;
            3, 12, 13: code = cpr_pkg::CODE_BEGIN_SESSION;
            4: code = cpr_pkg::CODE_CANCEL_REQ;
            5: code = cpr_pkg::CODE_VEND_APPROVED;
            6: code = cpr_pkg::CODE_VEND_DENIED;
            7: code = cpr_pkg::CODE_END_SESSION;
            8: code = cpr_pkg::CODE_CANCELLED;
            9: code = cpr_pkg::CODE_PERIPHERAL_ID;
            10: code = cpr_pkg::CODE_MALFUNCTION;
            11: code = cpr_pkg::CODE_CMD_OUT_SEQ;
            default: code = 8'($urandom_range(8'h0C, 8'hFF));
         endcase
         bytes.push_back(code);
         case (code)
            cpr_pkg::CODE_READER_CONFIG: extra = 7;
            cpr_pkg::CODE_VEND_APPROVED: extra = 2;
            cpr_pkg::CODE_MALFUNCTION: extra = 1;
            cpr_pkg::CODE_BEGIN_SESSION: extra = 7 + $urandom_range(0, 2);
            cpr_pkg::CODE_JUST_RESET, cpr_pkg::CODE_CANCEL_REQ,
               cpr_pkg::CODE_VEND_DENIED, cpr_pkg::CODE_END_SESSION,
               cpr_pkg::CODE_CANCELLED, cpr_pkg::CODE_CMD_OUT_SEQ: extra = 0;
            default: extra = $urandom_range(0, 4);
         endcase
         repeat (extra) bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) == 0 && bytes.size() > 1) begin
         keep = $urandom_range(1, bytes.size() - 1);
         while (bytes.size() > keep) void'(bytes.pop_back());
      end
   endtask

   task automatic check_report(input cpr_pkg::rsp_type got);
      cpr_pkg::rsp_type want;
      if (expected_reports.size() == 0) begin
         $error("unexpected response transaction: %h", got);
         error_count++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.event_flags !== want.event_flags) begin
         $error("event_flags: expected %h, got %h", want.event_flags, got.event_flags);
         error_count++;
      end
      if (got.received_amount !== want.received_amount) begin
         $error("received_amount: expected %0d, got %0d",
                want.received_amount, got.received_amount);
         error_count++;
      end
      if (got.payment_id !== want.payment_id) begin
         $error("payment_id: expected %h, got %h", want.payment_id, got.payment_id);
         error_count++;
      end
      if (got.payment_kind !== want.payment_kind) begin
         $error("payment_kind: expected %h, got %h", want.payment_kind, got.payment_kind);
         error_count++;
      end
   endtask

   // response side
   initial begin
      int stall;
      rsp_pop = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            stall = LONG_HOLD_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall = $urandom_range(0, sink_max_stall);
         end
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_report(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("cashless_poll_response_parser regression: fail");
         $finish;
      end
   end

   initial begin
      byte_queue_type resp_bytes;
      cpr_pkg::req_type item;
      int sent;
      logic [7:0] level;
      logic [14:0] scale;
      req_push = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = cpr_pkg::CSR_READER_LEVEL;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item.rx_byte = directed_rows[i].rx;
         item.last_byte = directed_rows[i].last;
         send_byte(item, directed_rows[i].typed, directed_rows[i].want);
      end
      drain_block();

      for (int p = 0; p < NUM_PHASES; p++) begin
         level = (phase_levels[p] == PICK_RANDOM) ? 8'($urandom_range(4, 254))
                                                  : 8'(phase_levels[p]);
         scale = (phase_scales[p] == PICK_RANDOM) ? 15'($urandom_range(0, SCALE_MAX))
                                                  : 15'(phase_scales[p]);
         program_settings(level, scale);
         // back-to-back traffic on some phases
         sender_max_gap = (p % 4 == 2) ? 0 : 3;
         sink_max_stall = (p % 4 == 2) ? 0 : 3;
         if (p == 1) hold_off_request = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_response(resp_bytes);
            foreach (resp_bytes[i]) begin
               item.rx_byte = resp_bytes[i];
               item.last_byte = (i == resp_bytes.size() - 1);
               send_byte(item, 1'b0, NOT_TYPED);
               sent++;
            end
         end
         drain_block();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("cashless_poll_response_parser regression: pass");
      else
         $display("cashless_poll_response_parser regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
src/cpr_pkg.sv
src/cpr_front.sv
src/cpr_queue.sv
src/cpr_back.sv
src/cashless_poll_response_parser.sv
tb/testbench.sv
